// ----- hdl/wpvs_pkg.sv -----
// Shared types and constants for the WAV PCM16 mono volume stream block.
// No dependencies; used by every module under hdl/.
package wpvs_pkg;

  // Header layout
  localparam int unsigned HEADER_BYTES = 44;
  localparam logic [5:0] HEADER_LAST = 6'(HEADER_BYTES - 1);
  localparam logic [5:0] POS_RIFF_END = 6'd4;
  localparam logic [5:0] POS_WAVE = 6'd8;
  localparam logic [5:0] POS_WAVE_END = 6'd12;
  localparam logic [5:0] POS_CH_LO = 6'd22;
  localparam logic [5:0] POS_CH_HI = 6'd23;
  localparam logic [5:0] POS_RATE_B0 = 6'd24;
  localparam logic [5:0] POS_RATE_B1 = 6'd25;
  localparam logic [5:0] POS_RATE_B2 = 6'd26;
  localparam logic [5:0] POS_RATE_B3 = 6'd27;
  localparam logic [5:0] POS_DEPTH_LO = 6'd34;
  localparam logic [5:0] POS_DEPTH_HI = 6'd35;

  localparam logic [7:0] RIFF_TAG [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0] WAVE_TAG [4] = '{8'h57, 8'h41, 8'h56, 8'h45};

  localparam logic [15:0] REQUIRED_DEPTH = 16'd16;
  localparam logic [15:0] CH_MONO = 16'd1;
  localparam logic [15:0] CH_STEREO = 16'd2;

  // x / 100 == (x >> 2) / 25; divide by 25 through a reciprocal,
  // exact for dividends below 2^22.
  localparam logic [21:0] RECIP_25 = 22'd2684355;
  localparam int unsigned RECIP_SHIFT = 26;

  localparam logic [17:0] SAMPLE_MAX_MAG = 18'd32767;
  localparam logic [17:0] SAMPLE_MIN_MAG = 18'd32768;
  localparam logic [15:0] SAMPLE_MAX = 16'h7FFF;
  localparam logic [15:0] SAMPLE_MIN = 16'h8000;

  // Configuration register indexes and reset values
  localparam logic [1:0] CFG_VOLUME = 2'd0;
  localparam logic [1:0] CFG_FLOOR = 2'd1;
  localparam logic [1:0] CFG_CEILING = 2'd2;
  localparam logic [7:0] VOLUME_RESET = 8'd50;
  localparam logic [7:0] FLOOR_RESET = 8'd0;
  localparam logic [7:0] CEILING_RESET = 8'd100;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_MAGIC    = 3'd1,
    ST_NOT_16BIT    = 3'd2,
    ST_BAD_CHANNELS = 3'd3,
    ST_SHORT        = 3'd4
  } status_t;

  // Parser -> gain stage. prim: a sample or verdict beat is pending;
  // endm: an end marker beat follows it.
  typedef struct packed {
    logic               prim;
    logic               endm;
    kind_t              kind;
    status_t            status;
    logic [15:0]        ch;
    logic [31:0]        rate;
    logic signed [16:0] mixed;
  } parse_rec_t;

  // Gain stage -> output stage: magnitude product and its sign.
  typedef struct packed {
    logic        prim;
    logic        endm;
    kind_t       kind;
    status_t     status;
    logic [15:0] ch;
    logic [31:0] rate;
    logic        neg;
    logic [23:0] prod;
  } gain_rec_t;

endpackage

// ----- hdl/wpvs_parse.sv -----
// Header parser and frame assembler: parse state plus the first pipeline register.
// Depends on wpvs_pkg.
module wpvs_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            file_byte,
  input  logic                  end_of_file,
  input  logic                  down_ready,
  output wpvs_pkg::parse_rec_t  rec
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_REJECT
  } phase_t;

  phase_t      phase, phase_next;
  logic [5:0]  hdr_pos, hdr_pos_next;
  logic        magic_ok, magic_ok_next;
  logic [15:0] channels, channels_next;
  logic [31:0] rate, rate_next;
  logic [15:0] depth, depth_next;
  logic [1:0]  frame_pos, frame_pos_next;
  logic [7:0]  partial, partial_next;
  logic [15:0] left, left_next;

  logic                 ready;
  logic                 accept;
  logic                 prim;
  wpvs_pkg::kind_t      kind;
  wpvs_pkg::status_t    status;
  wpvs_pkg::status_t    verdict;
  logic signed [16:0]   mixed;
  logic signed [16:0]   word_ext;
  logic signed [16:0]   pair_sum;
  logic signed [16:0]   pair_adj;
  wpvs_pkg::parse_rec_t rec_new;

  assign ready    = !(rec.prim || rec.endm) || down_ready;
  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  assign word_ext = {file_byte[7], file_byte, partial};
  assign pair_sum = {left[15], left} + word_ext;
  // divide by two, truncating toward zero
  assign pair_adj = pair_sum + 17'(pair_sum[16]);

  always_comb begin
    if (!magic_ok_next) begin
      verdict = wpvs_pkg::ST_BAD_MAGIC;
    end else if (depth_next != wpvs_pkg::REQUIRED_DEPTH) begin
      verdict = wpvs_pkg::ST_NOT_16BIT;
    end else if (channels_next != wpvs_pkg::CH_MONO &&
                 channels_next != wpvs_pkg::CH_STEREO) begin
      verdict = wpvs_pkg::ST_BAD_CHANNELS;
    end else begin
      verdict = wpvs_pkg::ST_OK;
    end
  end

  always_comb begin
    phase_next     = phase;
    hdr_pos_next   = hdr_pos;
    magic_ok_next  = magic_ok;
    channels_next  = channels;
    rate_next      = rate;
    depth_next     = depth;
    frame_pos_next = frame_pos;
    partial_next   = partial;
    left_next      = left;
    prim           = 1'b0;
    kind           = wpvs_pkg::KIND_SAMPLE;
    status         = wpvs_pkg::ST_OK;
    mixed          = '0;

    case (phase)
      PH_HEADER: begin
        if (hdr_pos < wpvs_pkg::POS_RIFF_END &&
            file_byte != wpvs_pkg::RIFF_TAG[hdr_pos[1:0]]) begin
          magic_ok_next = 1'b0;
        end
        if (hdr_pos >= wpvs_pkg::POS_WAVE && hdr_pos < wpvs_pkg::POS_WAVE_END &&
            file_byte != wpvs_pkg::WAVE_TAG[hdr_pos[1:0]]) begin
          magic_ok_next = 1'b0;
        end
        if (hdr_pos == wpvs_pkg::POS_CH_LO)    channels_next[7:0]  = file_byte;
        if (hdr_pos == wpvs_pkg::POS_CH_HI)    channels_next[15:8] = file_byte;
        if (hdr_pos == wpvs_pkg::POS_RATE_B0)  rate_next[7:0]      = file_byte;
        if (hdr_pos == wpvs_pkg::POS_RATE_B1)  rate_next[15:8]     = file_byte;
        if (hdr_pos == wpvs_pkg::POS_RATE_B2)  rate_next[23:16]    = file_byte;
        if (hdr_pos == wpvs_pkg::POS_RATE_B3)  rate_next[31:24]    = file_byte;
        if (hdr_pos == wpvs_pkg::POS_DEPTH_LO) depth_next[7:0]     = file_byte;
        if (hdr_pos == wpvs_pkg::POS_DEPTH_HI) depth_next[15:8]    = file_byte;
        hdr_pos_next = hdr_pos + 6'd1;
        if (hdr_pos == wpvs_pkg::HEADER_LAST) begin
          prim   = 1'b1;
          kind   = wpvs_pkg::KIND_HEADER;
          status = verdict;
          phase_next = (verdict == wpvs_pkg::ST_OK) ? PH_DATA : PH_REJECT;
        end else if (end_of_file) begin
          prim   = 1'b1;
          kind   = wpvs_pkg::KIND_HEADER;
          status = wpvs_pkg::ST_SHORT;
        end
      end
      PH_DATA: begin
        if (!frame_pos[0]) begin
          partial_next   = file_byte;
          frame_pos_next = frame_pos + 2'd1;
        end else if (channels == wpvs_pkg::CH_MONO) begin
          prim           = 1'b1;
          mixed          = word_ext;
          frame_pos_next = 2'd0;
        end else if (!frame_pos[1]) begin
          left_next      = word_ext[15:0];
          frame_pos_next = 2'd2;
        end else begin
          prim           = 1'b1;
          mixed          = pair_adj >>> 1;
          frame_pos_next = 2'd0;
        end
      end
      default: begin
      end
    endcase

    rec_new.prim   = prim;
    rec_new.endm   = end_of_file;
    rec_new.kind   = kind;
    rec_new.status = status;
    rec_new.ch     = (kind == wpvs_pkg::KIND_HEADER) ? channels_next : 16'd0;
    rec_new.rate   = (kind == wpvs_pkg::KIND_HEADER) ? rate_next : 32'd0;
    rec_new.mixed  = mixed;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_file)) begin
      phase     <= PH_HEADER;
      hdr_pos   <= '0;
      magic_ok  <= 1'b1;
      channels  <= '0;
      rate      <= '0;
      depth     <= '0;
      frame_pos <= '0;
      partial   <= '0;
      left      <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      hdr_pos   <= hdr_pos_next;
      magic_ok  <= magic_ok_next;
      channels  <= channels_next;
      rate      <= rate_next;
      depth     <= depth_next;
      frame_pos <= frame_pos_next;
      partial   <= partial_next;
      left      <= left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.prim <= 1'b0;
      rec.endm <= 1'b0;
    end else if (ready) begin
      if (accept && (prim || end_of_file)) begin
        rec <= rec_new;
      end else begin
        rec.prim <= 1'b0;
        rec.endm <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/wpvs_gain.sv -----
// Gain stage: clamps the volume and multiplies the sample magnitude by it.
// Depends on wpvs_pkg.
module wpvs_gain (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            volume_percent,
  input  logic [7:0]            volume_floor,
  input  logic [7:0]            volume_ceiling,
  input  wpvs_pkg::parse_rec_t  rec_in,
  output logic                  ready,
  input  logic                  down_ready,
  output wpvs_pkg::gain_rec_t   rec
);

  logic [7:0]  vol_lo;
  logic [7:0]  gain;
  logic [15:0] mag;

  // floor first, then the ceiling wins
  assign vol_lo = (volume_percent < volume_floor) ? volume_floor : volume_percent;
  assign gain   = (vol_lo > volume_ceiling) ? volume_ceiling : vol_lo;
  assign mag    = rec_in.mixed[16] ? 16'(-rec_in.mixed) : rec_in.mixed[15:0];
  assign ready  = !(rec.prim || rec.endm) || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.prim <= 1'b0;
      rec.endm <= 1'b0;
    end else if (ready) begin
      rec.prim   <= rec_in.prim;
      rec.endm   <= rec_in.endm;
      rec.kind   <= rec_in.kind;
      rec.status <= rec_in.status;
      rec.ch     <= rec_in.ch;
      rec.rate   <= rec_in.rate;
      rec.neg    <= rec_in.mixed[16];
      rec.prod   <= 24'(mag) * 24'(gain);
    end
  end

endmodule

// ----- hdl/wpvs_emit.sv -----
// Output stage: divide by 100, saturate, and present one or two beats per record.
// Depends on wpvs_pkg.
module wpvs_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  wpvs_pkg::gain_rec_t  rec_in,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           record_kind,
  output logic signed [15:0]   sample_out,
  output logic [2:0]           header_status,
  output logic [15:0]          channel_count,
  output logic [31:0]          rate_hz,
  output logic                 last_of_run
);

  logic                prim;
  logic                endm;
  wpvs_pkg::kind_t     kind;
  wpvs_pkg::status_t   status;
  logic [15:0]         ch;
  logic [31:0]         rate;
  logic [15:0]         sample;

  logic [43:0] quot_full;
  logic [17:0] quot;
  logic [15:0] sample_new;

  assign quot_full = 44'(rec_in.prod[23:2]) * 44'(wpvs_pkg::RECIP_25);
  assign quot      = quot_full[wpvs_pkg::RECIP_SHIFT +: 18];

  always_comb begin
    if (rec_in.neg) begin
      sample_new = (quot >= wpvs_pkg::SAMPLE_MIN_MAG) ? wpvs_pkg::SAMPLE_MIN
                                                      : 16'd0 - quot[15:0];
    end else begin
      sample_new = (quot > wpvs_pkg::SAMPLE_MAX_MAG) ? wpvs_pkg::SAMPLE_MAX
                                                     : quot[15:0];
    end
  end

  // record done once its last beat goes out
  assign out_valid = prim || endm;
  assign ready     = !out_valid || (!out_stall && !(prim && endm));

  always_ff @(posedge clk) begin
    if (rst) begin
      prim <= 1'b0;
      endm <= 1'b0;
    end else if (ready) begin
      prim   <= rec_in.prim;
      endm   <= rec_in.endm;
      kind   <= rec_in.kind;
      status <= rec_in.status;
      ch     <= rec_in.ch;
      rate   <= rec_in.rate;
      sample <= sample_new;
    end else if (!out_stall) begin
      prim <= 1'b0;
    end
  end

  assign record_kind   = prim ? kind : wpvs_pkg::KIND_END;
  assign sample_out    = prim ? sample : 16'sd0;
  assign header_status = prim ? status : wpvs_pkg::ST_OK;
  assign channel_count = prim ? ch : 16'd0;
  assign rate_hz       = prim ? rate : 32'd0;
  assign last_of_run   = !(prim && endm);

endmodule

// ----- hdl/wav_pcm16_mono_volume_stream_core.sv -----
// WAV PCM16 mono volume stream: parses the 44-byte header, downmixes and scales samples.
// An accepted byte's result passes the parse, gain and output registers before its first beat.
// Throughput: one byte per cycle while the output is not stalled; an end byte that also yields a sample or a verdict
// needs two output beats, the output register being the limit.
// Reset (rst, synchronous): header parse rearmed, pipeline empty, volume 50/0/100.
// Depends on wpvs_pkg, wpvs_parse, wpvs_gain, wpvs_emit.
module wav_pcm16_mono_volume_stream_core (
  input  logic               clk,
  input  logic               rst,
  // configuration writes
  input  logic               cfg_write_en,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  // byte input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         file_byte,
  input  logic               end_of_file,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         record_kind,
  output logic signed [15:0] sample_out,
  output logic [2:0]         header_status,
  output logic [15:0]        channel_count,
  output logic [31:0]        rate_hz,
  output logic               last_of_run
);

  // Volume registers. The user must write them only while the stream is idle, so the gain
  // stage may read them directly; the block itself does not enforce this.
  logic [7:0] volume_percent;
  logic [7:0] volume_floor;
  logic [7:0] volume_ceiling;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_percent <= wpvs_pkg::VOLUME_RESET;
      volume_floor   <= wpvs_pkg::FLOOR_RESET;
      volume_ceiling <= wpvs_pkg::CEILING_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        wpvs_pkg::CFG_VOLUME:  volume_percent <= cfg_data;
        wpvs_pkg::CFG_FLOOR:   volume_floor   <= cfg_data;
        wpvs_pkg::CFG_CEILING: volume_ceiling <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pipeline: parse -> gain multiply -> divide/saturate + output register.
  // Each stage loads when it is empty or its content moves on, so bubbles
  // squeeze out and a new byte enters while a result beat waits.
  wpvs_pkg::parse_rec_t parse_rec;
  wpvs_pkg::gain_rec_t  gain_rec;
  logic                 gain_ready;
  logic                 emit_ready;

  wpvs_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .file_byte   (file_byte),
    .end_of_file (end_of_file),
    .down_ready  (gain_ready),
    .rec         (parse_rec)
  );

  wpvs_gain u_gain (
    .clk            (clk),
    .rst            (rst),
    .volume_percent (volume_percent),
    .volume_floor   (volume_floor),
    .volume_ceiling (volume_ceiling),
    .rec_in         (parse_rec),
    .ready          (gain_ready),
    .down_ready     (emit_ready),
    .rec            (gain_rec)
  );

  // A record holds a sample or verdict beat, an end-marker beat, or both;
  // the end marker always goes last, and last_of_run is low only on the first of two beats.
  wpvs_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .rec_in        (gain_rec),
    .ready         (emit_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .record_kind   (record_kind),
    .sample_out    (sample_out),
    .header_status (header_status),
    .channel_count (channel_count),
    .rate_hz       (rate_hz),
    .last_of_run   (last_of_run)
  );

endmodule
